[hdl/assert_macros.svh]
// assertion macros shared by the checking code of the line parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line parser check failed (same cycle)");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line parser check failed (next cycle)");

`endif

[hdl/atrlp_pkg.sv]
// types, character constants and digit decode for the at response line parser
package atrlp_pkg;

    // framing states
    typedef enum logic [1:0] {
        FR_IDLE   = 2'd0,
        FR_GOT_CR = 2'd1,
        FR_TEXT   = 2'd2,
        FR_END_CR = 2'd3
    } t_frame;

    // modem status codes
    typedef enum logic [2:0] {
        ST_NOT_CONN = 3'd0,
        ST_NONE     = 3'd1,
        ST_OK       = 3'd2,
        ST_ERROR    = 3'd3,
        ST_TIME     = 3'd4,
        ST_PROMPT   = 3'd5
    } t_status;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_PROMPT = 8'h3E;

    localparam logic [15:0] TXT_OK     = "OK";
    localparam logic [39:0] TXT_ERROR  = "ERROR";
    localparam logic [39:0] TXT_CCLK   = "+CCLK";
    localparam logic [15:0] TXT_PROMPT = "> ";

    localparam logic [5:0] MIN_PER_HOUR = 6'd60;

    // line bytes that classification ever looks at (prefixes and the six digit pairs)
    localparam int KEPT_BYTES = 25;
    localparam int NUM_FIELDS = 6;
    localparam int FIELD_BASE = 8;
    localparam int FIELD_STEP = 3;

    // two ascii digits to a value, wrapping at 8 bits
    function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        h = hi - CH_ZERO;
        l = lo - CH_ZERO;
        return 8'(h * 8'd10) + l;
    endfunction

endpackage

[hdl/atrlp_if.sv]
// valid/ready channel interfaces for received bytes and parser results
interface atrlp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface atrlp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  modem_status;
    logic        line_done;
    logic [7:0]  clock_year;
    logic [7:0]  clock_month;
    logic [7:0]  clock_day;
    logic [7:0]  clock_hour;
    logic [7:0]  clock_minute;
    logic [7:0]  clock_second;
    logic [13:0] minute_of_day;

    modport source (
        output valid, output modem_status, output line_done,
        output clock_year, output clock_month, output clock_day,
        output clock_hour, output clock_minute, output clock_second,
        output minute_of_day, input ready
    );
    modport sink (
        input valid, input modem_status, input line_done,
        input clock_year, input clock_month, input clock_day,
        input clock_hour, input clock_minute, input clock_second,
        input minute_of_day, output ready
    );
endinterface

[hdl/at_response_line_parser.sv]
// at response line parser: frames modem reply lines and classifies them
//
// usage
//   i_rx  : one received modem byte per word (valid/ready)
//   o_res : one result word per byte: modem status after the byte, a
//           line-done flag, the held clock fields and the minute of day
//   lines look like CR LF text CR (CR*) LF; the text goes into a line store
//   and is classified at the closing LF as OK, ERROR, clock reply, prompt or none;
//   a bare '>' while idle sets the prompt status at once
// timing
//   a byte is held in the input register and is then worked into the
//   result register; one byte per cycle sustained while results are taken;
//   the rate is set by the single framing/classify pass between
//   the two registers
// stalls
//   while a result waits in the result register, one more byte is taken into
//   the input register; ready drops only when both are occupied
// reset
//   synchronous, active low: framing idle, count zero, line store zero,
//   status not connected, clock fields zero, both registers empty
`include "assert_macros.svh"

module at_response_line_parser #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    atrlp_rx_if.sink             i_rx,
    atrlp_res_if.source          o_res
);

    // count holds 0..LINE_DEPTH
    localparam int CW = $clog2(LINE_DEPTH + 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register valid and per-word flag
    logic r_out_valid;
    logic r_done;

    // parser state (also the held part of the result)
    atrlp_pkg::t_frame  r_frame, n_frame;
    atrlp_pkg::t_status r_status, n_status;
    logic [CW-1:0]      r_count, n_count;
    logic [7:0]         r_line [atrlp_pkg::KEPT_BYTES];
    logic [7:0]         r_time [atrlp_pkg::NUM_FIELDS];
    logic [7:0]         n_time [atrlp_pkg::NUM_FIELDS];

    logic               advance;
    logic               work;
    logic               store_wr;
    logic               line_done;
    logic               prompt_seen;
    atrlp_pkg::t_status line_class;

    // result register frees up when empty or taken
    assign advance    = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_in_valid || advance;
    assign work       = r_in_valid && advance;

    // framing next state
    always_comb begin
        n_frame = atrlp_pkg::FR_IDLE;
        unique case (r_frame)
            atrlp_pkg::FR_IDLE: begin
                n_frame = (r_in_byte == atrlp_pkg::CH_CR) ? atrlp_pkg::FR_GOT_CR
                                                          : atrlp_pkg::FR_IDLE;
            end
            atrlp_pkg::FR_GOT_CR: begin
                n_frame = (r_in_byte == atrlp_pkg::CH_LF) ? atrlp_pkg::FR_TEXT
                                                          : atrlp_pkg::FR_IDLE;
            end
            atrlp_pkg::FR_TEXT: begin
                n_frame = (r_in_byte == atrlp_pkg::CH_CR) ? atrlp_pkg::FR_END_CR
                                                          : atrlp_pkg::FR_TEXT;
            end
            atrlp_pkg::FR_END_CR: begin
                n_frame = (r_in_byte == atrlp_pkg::CH_CR) ? atrlp_pkg::FR_END_CR
                                                          : atrlp_pkg::FR_IDLE;
            end
        endcase
    end

    // framing outputs: store write, line end, early prompt and next count
    always_comb begin
        store_wr    = (r_frame == atrlp_pkg::FR_TEXT) && (r_in_byte != atrlp_pkg::CH_CR)
                      && (r_count < CW'(LINE_DEPTH));
        line_done   = (r_frame == atrlp_pkg::FR_END_CR) && (r_in_byte == atrlp_pkg::CH_LF);
        prompt_seen = (r_frame == atrlp_pkg::FR_IDLE) && (r_in_byte == atrlp_pkg::CH_PROMPT);
        if (n_frame != atrlp_pkg::FR_TEXT) begin
            n_count = '0;
        end else if (store_wr) begin
            n_count = CW'(r_count + 1'b1);
        end else begin
            n_count = r_count;
        end
    end

    // classify by fixed leading characters, first match wins
    always_comb begin
        if ({r_line[0], r_line[1]} == atrlp_pkg::TXT_OK) begin
            line_class = atrlp_pkg::ST_OK;
        end else if ({r_line[0], r_line[1], r_line[2], r_line[3], r_line[4]}
                     == atrlp_pkg::TXT_ERROR) begin
            line_class = atrlp_pkg::ST_ERROR;
        end else if ({r_line[0], r_line[1], r_line[2], r_line[3], r_line[4]}
                     == atrlp_pkg::TXT_CCLK) begin
            line_class = atrlp_pkg::ST_TIME;
        end else if ({r_line[0], r_line[1]} == atrlp_pkg::TXT_PROMPT) begin
            line_class = atrlp_pkg::ST_PROMPT;
        end else begin
            line_class = atrlp_pkg::ST_NONE;
        end
    end

    // next status and clock fields
    always_comb begin
        if (line_done) begin
            n_status = line_class;
        end else if (prompt_seen) begin
            n_status = atrlp_pkg::ST_PROMPT;
        end else begin
            n_status = r_status;
        end
        for (int k = 0; k < atrlp_pkg::NUM_FIELDS; k++) begin
            if (line_done && (line_class == atrlp_pkg::ST_TIME)) begin
                n_time[k] = atrlp_pkg::two_digits(
                    r_line[atrlp_pkg::FIELD_BASE + atrlp_pkg::FIELD_STEP * k],
                    r_line[atrlp_pkg::FIELD_BASE + atrlp_pkg::FIELD_STEP * k + 1]);
            end else begin
                n_time[k] = r_time[k];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_frame     <= atrlp_pkg::FR_IDLE;
            r_status    <= atrlp_pkg::ST_NOT_CONN;
            r_count     <= '0;
            for (int i = 0; i < atrlp_pkg::KEPT_BYTES; i++) begin
                r_line[i] <= '0;
            end
            for (int k = 0; k < atrlp_pkg::NUM_FIELDS; k++) begin
                r_time[k] <= '0;
            end
        end else if (work) begin
            r_out_valid <= 1'b1;
            r_done      <= line_done;
            r_frame     <= n_frame;
            r_status    <= n_status;
            r_count     <= n_count;
            // bytes beyond the kept prefix are never looked at
            for (int i = 0; i < atrlp_pkg::KEPT_BYTES; i++) begin
                if (store_wr && (r_count == CW'(i))) begin
                    r_line[i] <= r_in_byte;
                end
            end
            for (int k = 0; k < atrlp_pkg::NUM_FIELDS; k++) begin
                r_time[k] <= n_time[k];
            end
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // held state only changes when a new result is loaded, so it drives the payload
    assign o_res.valid         = r_out_valid;
    assign o_res.modem_status  = r_status;
    assign o_res.line_done     = r_done;
    assign o_res.clock_year    = r_time[0];
    assign o_res.clock_month   = r_time[1];
    assign o_res.clock_day     = r_time[2];
    assign o_res.clock_hour    = r_time[3];
    assign o_res.clock_minute  = r_time[4];
    assign o_res.clock_second  = r_time[5];
    assign o_res.minute_of_day = 14'(14'(r_time[3]) * 14'(atrlp_pkg::MIN_PER_HOUR))
                                 + 14'(r_time[4]);

    // checks
    `ASSERT_IMP(a_done_classified, i_clk, i_rst_n, o_res.valid && o_res.line_done, o_res.modem_status != atrlp_pkg::ST_NOT_CONN)
    `ASSERT_IMP(a_count_only_in_text, i_clk, i_rst_n, r_frame != atrlp_pkg::FR_TEXT, r_count == '0)
    `ASSERT_NXT(a_idle_after_line, i_clk, i_rst_n, work && line_done, r_frame == atrlp_pkg::FR_IDLE && r_count == '0)
    `ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, !i_rx.ready, r_in_valid && r_out_valid)

endmodule
